@@ hw/rtl/sliding_window_sender_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_SENDER_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define SWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication with a delayed consequent, ignored while in reset
`define SWS_ASSERT_LAT2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error(msg);

// Holds on the cycle after reset is applied
`define SWS_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/swsnd_pkg.sv @@
package swsnd_pkg;

  // Sequence space and field widths
  localparam int SEQ_SLOTS  = 8;
  localparam int SEQ_W      = $clog2(SEQ_SLOTS);
  localparam int DATA_W     = 64;
  localparam int WIN_W      = 3;
  localparam int DUP_W      = 4;
  localparam int FUNC_W     = 2;
  localparam int TMR_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Queue depth between stages
  localparam int QUEUE_DEPTH = 2;

  // Register reset values and the duplicate-count maximum
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 3'd4;
  localparam logic [DUP_W-1:0] DUP_LIMIT_RESET = 4'd3;
  localparam logic [DUP_W-1:0] DUP_MAX         = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT   = 1'b1;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_SEND    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // Timer action codes
  localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
  localparam logic [TMR_W-1:0] TMR_STOP  = 2'd1;
  localparam logic [TMR_W-1:0] TMR_START = 2'd2;

  // Internal command classes
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_SEND    = 2'd1,
    OP_ACK     = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  ack_number;
    logic              ack_intact;
    logic [SEQ_W-1:0]  expired_timer;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic              transmit;
    logic [SEQ_W-1:0]  tx_sequence;
    logic [DATA_W-1:0] tx_payload;
    logic              retransmission;
    logic [TMR_W-1:0]  timer_action;
    logic [SEQ_W-1:0]  timer_tag;
    logic [SEQ_W-1:0]  window_base;
    logic [SEQ_W-1:0]  next_sequence;
    logic              window_full;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  ack_number;
    logic [SEQ_W-1:0]  expired_timer;
  } cmd_t;

endpackage

@@ hw/rtl/swsnd_fifo.sv @@
module swsnd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/swsnd_front.sv @@
module swsnd_front (
  input  swsnd_pkg::in_t  in_data,
  output swsnd_pkg::cmd_t cmd
);

  // Classify the incoming transaction; corrupt acks and unused codes become no-ops
  always_comb begin
    cmd.payload       = in_data.payload;
    cmd.ack_number    = in_data.ack_number;
    cmd.expired_timer = in_data.expired_timer;
    case (in_data.func)
      swsnd_pkg::FUNC_SEND: begin
        cmd.op = swsnd_pkg::OP_SEND;
      end
      swsnd_pkg::FUNC_ACK: begin
        cmd.op = in_data.ack_intact ? swsnd_pkg::OP_ACK : swsnd_pkg::OP_NONE;
      end
      swsnd_pkg::FUNC_TIMEOUT: begin
        cmd.op = swsnd_pkg::OP_TIMEOUT;
      end
      default: begin
        cmd.op = swsnd_pkg::OP_NONE;
      end
    endcase
  end

endmodule

@@ hw/rtl/swsnd_back.sv @@
module swsnd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swsnd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swsnd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                cmd_valid,
  input  swsnd_pkg::cmd_t                     cmd,
  output logic                                cmd_pop,
  input  logic                                res_full,
  output logic                                res_push,
  output swsnd_pkg::out_t                     res
);

  localparam int SEQ_W = swsnd_pkg::SEQ_W;
  localparam int WIN_W = swsnd_pkg::WIN_W;
  localparam int DUP_W = swsnd_pkg::DUP_W;

  logic [WIN_W-1:0]            win_r;
  logic [DUP_W-1:0]            lim_r;
  logic [SEQ_W-1:0]            base_r, base_nxt;
  logic [SEQ_W-1:0]            next_r, next_nxt;
  logic [SEQ_W-1:0]            timed_r, timed_nxt;
  logic [DUP_W-1:0]            dup_r, dup_nxt;
  logic [swsnd_pkg::DATA_W-1:0] sent_buf_r [swsnd_pkg::SEQ_SLOTS];

  logic             go;
  logic [WIN_W-1:0] eff_win;
  logic [DUP_W-1:0] eff_lim;
  logic [DUP_W-1:0] dup_inc;
  logic [SEQ_W-1:0] outst;
  logic [SEQ_W-1:0] ack_off;
  logic [SEQ_W-1:0] outst_after;
  logic             win_full;
  logic             ack_ok;
  logic             buf_we;

  assign go       = cmd_valid && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  // Window and duplicate-limit clamping, saturating duplicate-count increment
  always_comb begin
    eff_win = (win_r == '0) ? WIN_W'(1) : win_r;
    if (eff_win > WIN_W'(swsnd_pkg::SEQ_SLOTS - 1)) begin
      eff_win = WIN_W'(swsnd_pkg::SEQ_SLOTS - 1);
    end
    eff_lim = (lim_r == '0) ? DUP_W'(1) : lim_r;
    dup_inc = (dup_r == swsnd_pkg::DUP_MAX) ? dup_r : dup_r + 1'b1;
  end

  assign outst    = next_r - base_r;
  assign win_full = (outst >= eff_win);
  assign ack_off  = cmd.ack_number - base_r;
  assign ack_ok   = (ack_off < outst);
  assign buf_we   = go && (cmd.op == swsnd_pkg::OP_SEND) && !win_full;

  // Execute one command
  always_comb begin
    base_nxt  = base_r;
    next_nxt  = next_r;
    timed_nxt = timed_r;
    dup_nxt   = dup_r;
    res       = '0;
    case (cmd.op)
      swsnd_pkg::OP_SEND: begin
        if (!win_full) begin
          if (base_r == next_r) begin
            timed_nxt        = base_r;
            res.timer_action = swsnd_pkg::TMR_START;
            res.timer_tag    = base_r;
          end
          res.accepted    = 1'b1;
          res.transmit    = 1'b1;
          res.tx_sequence = next_r;
          res.tx_payload  = cmd.payload;
          next_nxt        = next_r + 1'b1;
        end
      end
      swsnd_pkg::OP_ACK: begin
        if (ack_ok) begin
          base_nxt = cmd.ack_number + 1'b1;
          if (base_nxt == next_r) begin
            res.timer_action = swsnd_pkg::TMR_STOP;
            res.timer_tag    = timed_r;
          end else begin
            timed_nxt        = base_nxt;
            res.timer_action = swsnd_pkg::TMR_START;
            res.timer_tag    = base_nxt;
          end
          dup_nxt = '0;
        end else if (dup_inc >= eff_lim) begin
          // fast retransmit of the oldest outstanding entry
          if (base_r != next_r) begin
            res.transmit       = 1'b1;
            res.retransmission = 1'b1;
            res.tx_sequence    = base_r;
            res.tx_payload     = sent_buf_r[base_r];
          end
          dup_nxt = '0;
        end else begin
          dup_nxt = dup_inc;
        end
      end
      swsnd_pkg::OP_TIMEOUT: begin
        if (base_r != next_r) begin
          res.transmit       = 1'b1;
          res.retransmission = 1'b1;
          res.tx_sequence    = base_r;
          res.tx_payload     = sent_buf_r[base_r];
          dup_nxt            = '0;
          timed_nxt          = base_r;
          res.timer_action   = swsnd_pkg::TMR_START;
          res.timer_tag      = base_r;
        end else begin
          res.timer_action = swsnd_pkg::TMR_STOP;
          res.timer_tag    = cmd.expired_timer;
        end
      end
      default: begin
      end
    endcase
    outst_after       = next_nxt - base_nxt;
    res.window_base   = base_nxt;
    res.next_sequence = next_nxt;
    res.window_full   = (outst_after >= eff_win);
  end

  // Window state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= swsnd_pkg::WINDOW_RESET;
      lim_r   <= swsnd_pkg::DUP_LIMIT_RESET;
      base_r  <= '0;
      next_r  <= '0;
      timed_r <= '0;
      dup_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swsnd_pkg::CFG_WINDOW_SIZE: win_r <= cfg_data[WIN_W-1:0];
          swsnd_pkg::CFG_DUP_LIMIT:   lim_r <= cfg_data[DUP_W-1:0];
          default: begin
          end
        endcase
      end
      if (go) begin
        base_r  <= base_nxt;
        next_r  <= next_nxt;
        timed_r <= timed_nxt;
        dup_r   <= dup_nxt;
      end
    end
  end

  // Sent payload buffer, written at the next sequence number
  always_ff @(posedge clk) begin
    if (buf_we) begin
      sent_buf_r[next_r] <= cmd.payload;
    end
  end

endmodule

@@ hw/rtl/sliding_window_sender.sv @@
// Path: a transaction accepted into the command queue is registered there, then
// executed by the execute stage, whose result is registered into the result queue.
// Throughput: one transaction per cycle; the execute stage updates the window
// state and one buffer slot per cycle and stalls only when the result queue is full.
// Reset (rst_n low, synchronous) empties both queues, zeroes the window state and
// loads the register defaults; buffer contents are not cleared.
module sliding_window_sender #(
  parameter int QDEPTH = swsnd_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  swsnd_pkg::in_t                   in_data,
  output logic                             in_full,
  input  logic                             out_pop,
  output swsnd_pkg::out_t                  out_data,
  output logic                             out_empty,
  input  logic                             cfg_we,
  input  logic [swsnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swsnd_pkg::CFG_DATA_W-1:0] cfg_data
);

  swsnd_pkg::cmd_t cmd_in;
  swsnd_pkg::cmd_t cmd_q;
  swsnd_pkg::out_t res;
  logic            cmd_empty;
  logic            cmd_pop;
  logic            res_full;
  logic            res_push;

  // Classify incoming transactions
  swsnd_front u_front (
    .in_data (in_data),
    .cmd     (cmd_in)
  );

  // Command queue between front and back
  swsnd_fifo #(
    .WIDTH ($bits(swsnd_pkg::cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty)
  );

  // Window state and execution
  swsnd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue toward the consumer
  swsnd_fifo #(
    .WIDTH ($bits(swsnd_pkg::out_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

@@ hw/rtl/swsnd_checker.sv @@
`include "sliding_window_sender_defines.svh"

module swsnd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_push,
  input logic                             in_full,
  input logic                             out_pop,
  input swsnd_pkg::out_t                  out_data,
  input logic                             out_empty
);

  // Reset empties both queues
  `SWS_ASSERT_RST(a_reset_empty, out_empty && !in_full, "queues not empty after reset")

  // Every accepted transaction leaves a result waiting once it has passed the command queue and execute stage
  `SWS_ASSERT_LAT2(a_result_latency, in_push && !in_full, !out_empty,
                   "result missing after accept")

  // A result not taken holds its value
  `SWS_ASSERT_NEXT(a_result_hold, !out_empty && !out_pop,
                   !out_empty && $stable(out_data), "stalled result changed")

  // No transmit means no packet fields
  `SWS_ASSERT_NOW(a_idle_tx_zero, !out_empty && !out_data.transmit,
                  out_data.tx_sequence == '0 && out_data.tx_payload == '0 &&
                  !out_data.retransmission && !out_data.accepted,
                  "packet fields set without transmit")

endmodule

bind sliding_window_sender swsnd_checker u_checker (.*);
